// ===== rtl/bsrc_pkg.sv =====
package bsrc_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COEF_IDX_W = 13;
	localparam int COEF_W = 16;
	localparam int DELTA_W = 17;
	localparam int GUARD_SHIFT = 2;
	localparam int GAIN_SHIFT = 13;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_STEP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_SCALE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WING_LENGTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INTERP = 3'd4;

	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_COEF = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [19:0] time_step;
		logic [15:0] filter_step;
		logic [15:0] gain_scale;
		logic [13:0] wing_length;
		logic interpolate_coeffs;
	} cfg_t;

	typedef struct packed {
		cmd_t kind;
		logic signed [SAMPLE_W-1:0] sample;
		logic [COEF_IDX_W-1:0] coef_index;
		logic signed [COEF_W-1:0] coef_value;
		logic signed [DELTA_W-1:0] coef_delta;
	} entry_t;

	typedef struct packed {
		logic last_of_run;
		logic signed [SAMPLE_W-1:0] out_sample;
	} result_t;

endpackage

// ===== rtl/bsrc_ram.sv =====
module bsrc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/bsrc_fifo.sv =====
module bsrc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [WIDTH-1:0] din,
	output logic full,
	input logic pop,
	output logic [WIDTH-1:0] dout,
	output logic empty
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] buf_q [DEPTH];
	logic [AW-1:0] rd_q, wr_q;
	logic [AW:0] count_q;
	logic do_push, do_pop;

	assign full = (count_q == (AW+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign dout = buf_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/bsrc_back.sv =====
module bsrc_back #(
	parameter int PHASE_BITS = 15,
	parameter int INTERP_BITS = 7,
	parameter int PRODUCT_SHIFT = 14,
	parameter int COEF_DEPTH = 8192,
	parameter int HISTORY_DEPTH = 1024,
	parameter int MAX_OUTPUTS = 16
) (
	input logic clk,
	input logic arst_n,
	input bsrc_pkg::cfg_t cfg,
	input logic q_empty,
	input bsrc_pkg::entry_t q_data,
	output logic q_pop,
	input logic r_full,
	output logic r_push,
	output bsrc_pkg::result_t r_data,
	output logic clearing
);

	localparam int HAW = $clog2(HISTORY_DEPTH);
	localparam int CAW = $clog2(COEF_DEPTH);
	localparam int REACH = HISTORY_DEPTH / 2;
	localparam int TP_W = ((HAW - 1 + PHASE_BITS > 20) ? HAW - 1 + PHASE_BITS : 20) + 2;
	localparam int HO_W = ((CAW + 1 + INTERP_BITS > 17) ? CAW + 1 + INTERP_BITS : 17) + 2;
	localparam int CNT_W = $clog2(MAX_OUTPUTS + 1);
	localparam int DP_W = bsrc_pkg::DELTA_W + INTERP_BITS + 1;
	localparam int C_W = 18;
	localparam int PR_W = C_W + bsrc_pkg::SAMPLE_W;
	localparam int ACC_W = PR_W + 1 - PRODUCT_SHIFT + HAW;
	localparam int GP_W = ACC_W + 17;
	localparam int DIV_W = 20;
	localparam int DI_W = $clog2(PHASE_BITS + 2);
	localparam int CR_W = bsrc_pkg::COEF_W + bsrc_pkg::DELTA_W;
	localparam logic signed [TP_W-1:0] UNIT = TP_W'(1) << PHASE_BITS;
	localparam logic signed [TP_W-1:0] TP_RESET = TP_W'(REACH) << PHASE_BITS;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_CHECK, S_SETUP_L, S_SETUP_R, S_TAP_RD, S_TAP_MUL1,
		S_TAP_MUL2, S_TAP_ACC, S_GAIN, S_EMIT, S_DIV, S_DIV_END
	} state_t;

	state_t state_q;
	logic signed [TP_W-1:0] tp_q;
	logic [HAW-1:0] wp_q, center_q, taps_q, clr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PHASE_BITS-1:0] ph_q;
	logic [HO_W-1:0] ho_q;
	logic right_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [DP_W-1:0] dprod_q;
	logic signed [PR_W-1:0] prod_q;
	logic signed [GP_W-1:0] gprod_q;
	logic [DIV_W-1:0] div_r_q;
	logic [PHASE_BITS:0] div_n_q;
	logic [DI_W-1:0] div_i_q;

	logic [19:0] dtb;
	logic [15:0] dhb;
	logic [15:0] lim, thresh;
	logic tap_done;
	logic hist_we, coef_we, rd_en;
	logic [HAW-1:0] hist_waddr, hist_raddr;
	logic signed [bsrc_pkg::SAMPLE_W-1:0] hist_wdata, hist_rdata;
	logic [CR_W-1:0] coef_rdata;
	logic signed [bsrc_pkg::COEF_W-1:0] cval;
	logic signed [bsrc_pkg::DELTA_W-1:0] cdelta;
	logic signed [DP_W-1:0] dprod_sh;
	logic signed [C_W-1:0] c_val;
	logic signed [PR_W-1:0] prod_sh;
	logic signed [ACC_W-1:0] acc_g;
	logic signed [GP_W-1:0] gsh;
	logic signed [bsrc_pkg::SAMPLE_W-1:0] sat_val;
	logic signed [TP_W-1:0] dtb_s, tp_plus, tp_minus;
	logic [PHASE_BITS+15:0] ho_mul;
	logic [PHASE_BITS-1:0] phr, ph_mux;
	logic [DIV_W:0] r_sh;
	logic emit_last;

	assign dtb = (cfg.time_step == '0) ? 20'd1 : cfg.time_step;
	assign dhb = (cfg.filter_step == '0) ? 16'd1 : cfg.filter_step;
	assign lim = ({2'b0, cfg.wing_length} > 16'(COEF_DEPTH)) ? 16'(COEF_DEPTH)
		: {2'b0, cfg.wing_length};
	assign thresh = right_q ? lim - 16'd1 : lim;
	assign tap_done = (taps_q == HAW'(REACH)) || (right_q && lim == '0)
		|| (ho_q >= (HO_W'(thresh) << INTERP_BITS));

	assign clearing = (state_q == S_CLEAR);
	assign q_pop = (state_q == S_IDLE) && !q_empty;
	assign coef_we = q_pop && (q_data.kind == bsrc_pkg::CMD_COEF);
	assign hist_we = clearing || (q_pop && q_data.kind == bsrc_pkg::CMD_SAMPLE);
	assign hist_waddr = clearing ? clr_q : wp_q;
	assign hist_wdata = clearing ? '0 : q_data.sample;
	assign hist_raddr = right_q ? center_q + taps_q : center_q - taps_q;
	assign rd_en = (state_q == S_TAP_RD) && !tap_done;

	bsrc_ram #(.WIDTH(bsrc_pkg::SAMPLE_W), .DEPTH(HISTORY_DEPTH)) u_hist (
		.clk(clk),
		.we(hist_we),
		.waddr(hist_waddr),
		.wdata(hist_wdata),
		.re(rd_en),
		.raddr(hist_raddr),
		.rdata(hist_rdata)
	);

	bsrc_ram #(.WIDTH(CR_W), .DEPTH(COEF_DEPTH)) u_coef (
		.clk(clk),
		.we(coef_we),
		.waddr(CAW'(q_data.coef_index)),
		.wdata({q_data.coef_value, q_data.coef_delta}),
		.re(rd_en),
		.raddr(ho_q[INTERP_BITS +: CAW]),
		.rdata(coef_rdata)
	);

	assign cval = coef_rdata[CR_W-1 -: bsrc_pkg::COEF_W];
	assign cdelta = coef_rdata[bsrc_pkg::DELTA_W-1:0];
	assign dprod_sh = dprod_q >>> INTERP_BITS;
	assign c_val = C_W'(cval) + (cfg.interpolate_coeffs ? dprod_sh[C_W-1:0] : C_W'(0));
	assign prod_sh = prod_q >>> PRODUCT_SHIFT;
	assign acc_g = acc_q >>> bsrc_pkg::GUARD_SHIFT;
	assign gsh = gprod_q >>> bsrc_pkg::GAIN_SHIFT;
	assign sat_val = (gsh > GP_W'(32767)) ? 16'sd32767
		: (gsh < -GP_W'(32768)) ? -16'sd32768 : gsh[bsrc_pkg::SAMPLE_W-1:0];
	assign dtb_s = TP_W'(dtb);
	assign tp_plus = tp_q + dtb_s;
	assign tp_minus = tp_q - UNIT;
	assign phr = PHASE_BITS'(0) - ph_q;
	assign ph_mux = (state_q == S_SETUP_R) ? phr : ph_q;
	assign ho_mul = ph_mux * dhb;
	assign r_sh = {div_r_q, div_n_q[PHASE_BITS]};
	assign emit_last = (tp_plus >= 0) || (cnt_q == CNT_W'(MAX_OUTPUTS - 1));

	assign r_push = (state_q == S_EMIT) && !r_full;
	assign r_data.out_sample = sat_val;
	assign r_data.last_of_run = emit_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			tp_q <= TP_RESET;
			wp_q <= '0;
			clr_q <= '0;
			cnt_q <= '0;
			right_q <= 1'b0;
			taps_q <= '0;
			div_i_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == HAW'(HISTORY_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_pop && q_data.kind == bsrc_pkg::CMD_SAMPLE) begin
						wp_q <= wp_q + 1'b1;
						center_q <= wp_q - HAW'(REACH);
						tp_q <= tp_minus;
						cnt_q <= '0;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (tp_q < 0 && cnt_q < CNT_W'(MAX_OUTPUTS)) begin
						ph_q <= tp_q[PHASE_BITS-1:0];
						acc_q <= '0;
						state_q <= S_SETUP_L;
					end else if (tp_q < 0) begin
						div_n_q <= (PHASE_BITS+1)'(-tp_q);
						div_r_q <= '0;
						div_i_q <= '0;
						state_q <= S_DIV;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SETUP_L: begin
					ho_q <= HO_W'(ho_mul >> PHASE_BITS);
					taps_q <= '0;
					right_q <= 1'b0;
					state_q <= S_TAP_RD;
				end
				S_SETUP_R: begin
					ho_q <= HO_W'(ho_mul >> PHASE_BITS) + ((phr == '0) ? HO_W'(dhb) : '0);
					taps_q <= '0;
					right_q <= 1'b1;
					state_q <= S_TAP_RD;
				end
				S_TAP_RD: begin
					if (tap_done) begin
						state_q <= right_q ? S_GAIN : S_SETUP_R;
					end else begin
						state_q <= S_TAP_MUL1;
					end
				end
				S_TAP_MUL1: begin
					dprod_q <= cdelta * $signed({1'b0, ho_q[INTERP_BITS-1:0]});
					state_q <= S_TAP_MUL2;
				end
				S_TAP_MUL2: begin
					prod_q <= c_val * hist_rdata;
					state_q <= S_TAP_ACC;
				end
				S_TAP_ACC: begin
					acc_q <= acc_q + ACC_W'(prod_sh) + ACC_W'(prod_q[PRODUCT_SHIFT-1]);
					ho_q <= ho_q + HO_W'(dhb);
					taps_q <= taps_q + 1'b1;
					state_q <= S_TAP_RD;
				end
				S_GAIN: begin
					gprod_q <= acc_g * $signed({1'b0, cfg.gain_scale});
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!r_full) begin
						tp_q <= tp_plus;
						cnt_q <= cnt_q + 1'b1;
						right_q <= 1'b0;
						state_q <= S_CHECK;
					end
				end
				S_DIV: begin
					div_n_q <= div_n_q << 1;
					div_r_q <= (r_sh >= {1'b0, dtb}) ? DIV_W'(r_sh - {1'b0, dtb})
						: DIV_W'(r_sh);
					div_i_q <= div_i_q + 1'b1;
					if (div_i_q == DI_W'(PHASE_BITS)) begin
						state_q <= S_DIV_END;
					end
				end
				S_DIV_END: begin
					tp_q <= (div_r_q == '0) ? '0 : TP_W'(dtb - div_r_q);
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/bandlimited_sample_rate_converter.sv =====
// Bandlimited sample rate converter.
// Input queue: push/full. cmd 0 delivers an audio sample, cmd 1 writes one
// coefficient/delta pair into the filter table (indexes past the table are
// dropped). Each sample may produce up to MAX_OUTPUTS results, popped from
// the result queue with empty/pop; last_of_run flags the final result of
// the transactions caused by one sample. Configuration is written through
// cfg_we/cfg_index/cfg_data; the user must write it only while the block is
// idle, and the block itself does not enforce this. A front stage
// classifies transactions into a command queue; the back end runs one
// multiply-accumulate engine, taking each tap through read, multiply and
// accumulate steps. A sample whose instants beyond MAX_OUTPUTS are skipped
// also runs a serial division to find its next output instant.
// After reset the sample history is cleared, one entry a cycle, until all
// HISTORY_DEPTH entries are zero; full stays high until then.
// When the receiver stalls, the result queue fills and the engine holds its
// result; the command queue keeps taking transactions until it is full.
module bandlimited_sample_rate_converter #(
	parameter int PHASE_BITS = 15,
	parameter int INTERP_BITS = 7,
	parameter int PRODUCT_SHIFT = 14,
	parameter int COEF_DEPTH = 8192,
	parameter int HISTORY_DEPTH = 1024,
	parameter int MAX_OUTPUTS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic cmd,
	input logic signed [15:0] sample,
	input logic [12:0] coef_index,
	input logic signed [15:0] coef_value,
	input logic signed [16:0] coef_delta,
	output logic empty,
	input logic pop,
	output logic signed [15:0] out_sample,
	output logic last_of_run,
	input logic cfg_we,
	input logic [bsrc_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [bsrc_pkg::CFG_DATA_W-1:0] cfg_data
);

	bsrc_pkg::cfg_t cfg_q;
	bsrc_pkg::entry_t in_entry, q_data;
	bsrc_pkg::result_t r_data, r_out;
	logic cmdq_full, q_empty, q_pop, r_full, r_push, clearing, keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_step <= 20'd32768;
			cfg_q.filter_step <= 16'd32768;
			cfg_q.gain_scale <= '0;
			cfg_q.wing_length <= 14'd1;
			cfg_q.interpolate_coeffs <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bsrc_pkg::REG_TIME_STEP: cfg_q.time_step <= cfg_data;
				bsrc_pkg::REG_FILTER_STEP: cfg_q.filter_step <= cfg_data[15:0];
				bsrc_pkg::REG_GAIN_SCALE: cfg_q.gain_scale <= cfg_data[15:0];
				bsrc_pkg::REG_WING_LENGTH: cfg_q.wing_length <= cfg_data[13:0];
				bsrc_pkg::REG_INTERP: cfg_q.interpolate_coeffs <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign in_entry.kind = bsrc_pkg::cmd_t'(cmd);
	assign in_entry.sample = sample;
	assign in_entry.coef_index = coef_index;
	assign in_entry.coef_value = coef_value;
	assign in_entry.coef_delta = coef_delta;

	assign full = cmdq_full || clearing;
	assign keep = (cmd == bsrc_pkg::CMD_SAMPLE) || (32'(coef_index) < 32'(COEF_DEPTH));

	bsrc_fifo #(.WIDTH($bits(bsrc_pkg::entry_t)), .DEPTH(2)) u_cmdq (
		.clk(clk),
		.arst_n(arst_n),
		.push(push && !full && keep),
		.din(in_entry),
		.full(cmdq_full),
		.pop(q_pop),
		.dout(q_data),
		.empty(q_empty)
	);

	bsrc_back #(
		.PHASE_BITS(PHASE_BITS),
		.INTERP_BITS(INTERP_BITS),
		.PRODUCT_SHIFT(PRODUCT_SHIFT),
		.COEF_DEPTH(COEF_DEPTH),
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.MAX_OUTPUTS(MAX_OUTPUTS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_empty(q_empty),
		.q_data(q_data),
		.q_pop(q_pop),
		.r_full(r_full),
		.r_push(r_push),
		.r_data(r_data),
		.clearing(clearing)
	);

	bsrc_fifo #(.WIDTH($bits(bsrc_pkg::result_t)), .DEPTH(2)) u_resq (
		.clk(clk),
		.arst_n(arst_n),
		.push(r_push),
		.din(r_data),
		.full(r_full),
		.pop(pop),
		.dout(r_out),
		.empty(empty)
	);

	assign out_sample = r_out.out_sample;
	assign last_of_run = r_out.last_of_run;

endmodule
